// ===== rtl/core/xmcs_pkg.sv =====
// Package for the XMODEM-1K CRC sender: control characters, phase and action codes,
// register indexes and the CRC-16/XMODEM byte update. No dependencies.
package xmcs_pkg;

    localparam int PACKET_BYTES_DEF = 1024;
    localparam int SHORT_BYTES      = 128;

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_PAD = 8'h1A;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [2:0] PH_INIT   = 3'd0;
    localparam logic [2:0] PH_ACCEPT = 3'd1;
    localparam logic [2:0] PH_SEND   = 3'd2;
    localparam logic [2:0] PH_WAIT   = 3'd3;
    localparam logic [2:0] PH_EOT    = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;
    localparam logic [2:0] PH_CANCEL = 3'd6;
    localparam logic [2:0] PH_ERROR  = 3'd7;

    localparam logic [2:0] ACT_START   = 3'd0;
    localparam logic [2:0] ACT_PAYLOAD = 3'd1;
    localparam logic [2:0] ACT_END     = 3'd2;
    localparam logic [2:0] ACT_PULL    = 3'd3;
    localparam logic [2:0] ACT_PARTNER = 3'd4;
    localparam logic [2:0] ACT_TIMEOUT = 3'd5;

    localparam logic REG_MAX_RETRIES  = 1'b0;
    localparam logic REG_LONG_PACKETS = 1'b1;

    localparam logic [2:0] MAX_RETRIES_RST = 3'd3;

    typedef logic [15:0] crc_t;

    function automatic crc_t crc_add(input crc_t crc, input logic [7:0] b);
        crc_t c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/xmcs_store.sv =====
// Packet store for the XMODEM-1K CRC sender: one write port, one registered read port.
// Depends on nothing beyond its parameter.
module xmcs_store #(
    parameter int PACKET_BYTES = 1024
) (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [$clog2(PACKET_BYTES)-1:0] wr_addr,
    input  logic [7:0]                      wr_data,
    input  logic [$clog2(PACKET_BYTES)-1:0] rd_addr,
    output logic [7:0]                      rd_data
);

    logic [7:0] mem [PACKET_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/xmodem_1k_crc_sender.sv =====
// XMODEM-1K sender with CRC-16/XMODEM: top level with state, framing and result register.
// Depends on xmcs_pkg and xmcs_store.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  in       | in_valid / in_ready  | action[2:0], value[7:0]
//  out      | out_valid / out_ready| tx_valid, tx_byte, frame_end, refused, status,
//           |                      | packet_number
//  cfg      | cfg_valid / cfg_ready| cfg_index[0:0], cfg_data[2:0]
//
// One transaction per cycle while out_ready is high; its result is registered in the output.
// The store is read ahead from the next send index, so it holds the byte the next pull needs.
// The input takes a transaction whenever the output register is empty or being drained.
// Reset clears all control state at once; the store needs no clearing pass.
// cfg_ready is always high.
module xmodem_1k_crc_sender #(
    parameter int PACKET_BYTES = xmcs_pkg::PACKET_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] action,
    input  logic [7:0] value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       tx_valid,
    output logic [7:0] tx_byte,
    output logic       frame_end,
    output logic       refused,
    output logic [2:0] status,
    output logic [7:0] packet_number,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [0:0] cfg_index,
    input  logic [2:0] cfg_data
);
    import xmcs_pkg::*;

    localparam int ADDR_W = $clog2(PACKET_BYTES);
    localparam int FILL_W = $clog2(PACKET_BYTES + 1);
    localparam int SIDX_W = $clog2(PACKET_BYTES + 6);

    logic [2:0]        max_retries_reg;
    logic              long_packets_reg;
    logic [FILL_W-1:0] fill_count_reg, fill_count_next;
    logic [SIDX_W-1:0] send_index_reg, send_index_next;
    logic [7:0]        seq_number_reg, seq_number_next;
    crc_t              crc_reg, crc_next;
    logic [2:0]        retry_count_reg, retry_count_next;
    logic [2:0]        phase_reg, phase_next;
    logic              one_cancel_reg, one_cancel_next;
    logic              last_packet_reg, last_packet_next;
    logic              eot_sent_reg, eot_sent_next;

    logic              out_valid_reg;
    logic              tx_valid_reg, tx_valid_next;
    logic [7:0]        tx_byte_reg, tx_byte_next;
    logic              frame_end_reg, frame_end_next;
    logic              refused_reg, refused_next;

    logic              in_fire;
    logic              st_we;
    logic [ADDR_W-1:0] st_waddr;
    logic [ADDR_W-1:0] st_raddr;
    logic [7:0]        st_rdata;

    logic [SIDX_W-1:0] size_w;
    logic [SIDX_W-1:0] data_idx;
    logic [SIDX_W-1:0] next_data_idx;
    logic [FILL_W-1:0] fill_inc;
    logic              pad_sel;
    logic [7:0]        data_byte;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign size_w        = long_packets_reg ? SIDX_W'(PACKET_BYTES) : SIDX_W'(SHORT_BYTES);
    assign data_idx      = send_index_reg - SIDX_W'(3);
    assign next_data_idx = send_index_next - SIDX_W'(3);
    assign st_raddr      = next_data_idx[ADDR_W-1:0];
    assign st_waddr      = fill_count_reg[ADDR_W-1:0];
    assign pad_sel       = !(data_idx < SIDX_W'(fill_count_reg))
                        || !(data_idx < SIDX_W'(PACKET_BYTES));
    assign data_byte     = pad_sel ? CH_PAD : st_rdata;

    xmcs_store #(
        .PACKET_BYTES(PACKET_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (value),
        .rd_addr (st_raddr),
        .rd_data (st_rdata)
    );

    always_comb
    begin
        fill_count_next  = fill_count_reg;
        send_index_next  = send_index_reg;
        seq_number_next  = seq_number_reg;
        crc_next         = crc_reg;
        retry_count_next = retry_count_reg;
        phase_next       = phase_reg;
        one_cancel_next  = one_cancel_reg;
        last_packet_next = last_packet_reg;
        eot_sent_next    = eot_sent_reg;
        tx_valid_next    = 1'b0;
        tx_byte_next     = 8'h00;
        frame_end_next   = 1'b0;
        refused_next     = 1'b0;
        st_we            = 1'b0;
        fill_inc         = fill_count_reg;

        if (in_fire)
        begin
            case (action)
                ACT_START:
                begin
                    fill_count_next  = '0;
                    send_index_next  = '0;
                    seq_number_next  = 8'd1;
                    crc_next         = '0;
                    retry_count_next = '0;
                    one_cancel_next  = 1'b0;
                    last_packet_next = 1'b0;
                    eot_sent_next    = 1'b0;
                    phase_next       = PH_ACCEPT;
                end
                ACT_PAYLOAD:
                begin
                    if (phase_reg != PH_ACCEPT)
                    begin
                        refused_next = 1'b1;
                    end
                    else
                    begin
                        if (fill_count_reg < FILL_W'(PACKET_BYTES))
                        begin
                            st_we    = 1'b1;
                            fill_inc = fill_count_reg + FILL_W'(1);
                        end
                        fill_count_next = fill_inc;
                        if (SIDX_W'(fill_inc) >= size_w)
                        begin
                            retry_count_next = '0;
                            phase_next       = PH_SEND;
                            send_index_next  = '0;
                            crc_next         = '0;
                        end
                    end
                end
                ACT_END:
                begin
                    if (phase_reg == PH_ACCEPT)
                    begin
                        if (fill_count_reg == '0)
                        begin
                            phase_next    = PH_EOT;
                            eot_sent_next = 1'b0;
                        end
                        else
                        begin
                            last_packet_next = 1'b1;
                            retry_count_next = '0;
                            phase_next       = PH_SEND;
                            send_index_next  = '0;
                            crc_next         = '0;
                        end
                    end
                end
                ACT_PULL:
                begin
                    if (phase_reg == PH_SEND)
                    begin
                        tx_valid_next   = 1'b1;
                        send_index_next = send_index_reg + SIDX_W'(1);
                        if (send_index_reg == SIDX_W'(0))
                        begin
                            tx_byte_next = long_packets_reg ? CH_STX : CH_SOH;
                        end
                        else if (send_index_reg == SIDX_W'(1))
                        begin
                            tx_byte_next = seq_number_reg;
                        end
                        else if (send_index_reg == SIDX_W'(2))
                        begin
                            tx_byte_next = ~seq_number_reg;
                        end
                        else if (send_index_reg < size_w + SIDX_W'(3))
                        begin
                            tx_byte_next = data_byte;
                            crc_next     = crc_add(crc_reg, data_byte);
                        end
                        else if (send_index_reg == size_w + SIDX_W'(3))
                        begin
                            tx_byte_next = crc_reg[15:8];
                        end
                        else
                        begin
                            tx_byte_next    = crc_reg[7:0];
                            frame_end_next  = 1'b1;
                            phase_next      = PH_WAIT;
                            one_cancel_next = 1'b0;
                        end
                    end
                    else if (phase_reg == PH_EOT && !eot_sent_reg)
                    begin
                        tx_valid_next  = 1'b1;
                        tx_byte_next   = CH_EOT;
                        frame_end_next = 1'b1;
                        eot_sent_next  = 1'b1;
                    end
                end
                ACT_PARTNER, ACT_TIMEOUT:
                begin
                    if (phase_reg == PH_WAIT)
                    begin
                        if (action == ACT_PARTNER && one_cancel_reg && value == CH_CAN)
                        begin
                            phase_next = PH_CANCEL;
                        end
                        else if (action == ACT_PARTNER && !one_cancel_reg && value == CH_ACK)
                        begin
                            seq_number_next  = seq_number_reg + 8'd1;
                            retry_count_next = '0;
                            fill_count_next  = '0;
                            if (last_packet_reg)
                            begin
                                phase_next    = PH_EOT;
                                eot_sent_next = 1'b0;
                            end
                            else
                            begin
                                phase_next = PH_ACCEPT;
                            end
                        end
                        else if (action == ACT_PARTNER && !one_cancel_reg && value == CH_CAN)
                        begin
                            one_cancel_next = 1'b1;
                        end
                        else
                        begin
                            // failed attempt: resend or give up
                            one_cancel_next = 1'b0;
                            if (retry_count_reg >= max_retries_reg)
                            begin
                                phase_next = PH_ERROR;
                            end
                            else
                            begin
                                retry_count_next = retry_count_reg + 3'd1;
                                phase_next       = PH_SEND;
                                send_index_next  = '0;
                                crc_next         = '0;
                            end
                        end
                    end
                    else if (phase_reg == PH_EOT && eot_sent_reg)
                    begin
                        if (action == ACT_PARTNER && value == CH_ACK)
                            phase_next = PH_DONE;
                        else
                            phase_next = PH_ERROR;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_retries_reg  <= MAX_RETRIES_RST;
            long_packets_reg <= 1'b1;
            fill_count_reg   <= '0;
            send_index_reg   <= '0;
            seq_number_reg   <= 8'd1;
            crc_reg          <= '0;
            retry_count_reg  <= '0;
            phase_reg        <= PH_INIT;
            one_cancel_reg   <= 1'b0;
            last_packet_reg  <= 1'b0;
            eot_sent_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MAX_RETRIES:  max_retries_reg  <= cfg_data;
                    REG_LONG_PACKETS: long_packets_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            fill_count_reg  <= fill_count_next;
            send_index_reg  <= send_index_next;
            seq_number_reg  <= seq_number_next;
            crc_reg         <= crc_next;
            retry_count_reg <= retry_count_next;
            phase_reg       <= phase_next;
            one_cancel_reg  <= one_cancel_next;
            last_packet_reg <= last_packet_next;
            eot_sent_reg    <= eot_sent_next;
            if (in_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            tx_valid_reg  <= tx_valid_next;
            tx_byte_reg   <= tx_byte_next;
            frame_end_reg <= frame_end_next;
            refused_reg   <= refused_next;
        end
    end

    // status and packet number track the state registers, which only move on a transaction
    assign out_valid     = out_valid_reg;
    assign tx_valid      = tx_valid_reg;
    assign tx_byte       = tx_byte_reg;
    assign frame_end     = frame_end_reg;
    assign refused       = refused_reg;
    assign status        = phase_reg;
    assign packet_number = seq_number_reg;

endmodule

// ===== rtl/core/xmcs_checker.sv =====
// Port-level checks for the XMODEM-1K CRC sender, bound to the top level.
// Depends on xmcs_pkg and xmodem_1k_crc_sender.
module xmcs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [2:0] action,
    input logic       out_valid,
    input logic       out_ready,
    input logic       tx_valid,
    input logic [7:0] tx_byte,
    input logic       frame_end,
    input logic       refused,
    input logic [2:0] status,
    input logic [7:0] packet_number
);
    import xmcs_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(status))
        else $error("result changed while stalled");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("transaction without result");

    a_idle_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tx_valid |-> tx_byte == 8'h00 && !frame_end)
        else $error("byte or frame end without tx_valid");

    a_refused_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && refused |-> status != PH_ACCEPT && !tx_valid)
        else $error("refused while accepting");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action == ACT_START
        |=> status == PH_ACCEPT && packet_number == 8'd1)
        else $error("start did not restart the transfer");

endmodule

bind xmodem_1k_crc_sender xmcs_checker u_xmcs_checker (.*);
